[hw/rtl/htt_pkg.sv]
// shared types and constants of the handle to id translation table
`timescale 1ns / 1ps
package htt_pkg;

	localparam int TABLE_ENTRIES = 256;
	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int ENT_W = 31 + 64 + 64;

	localparam logic [1:0] CMD_LOOKUP  = 2'd0;
	localparam logic [1:0] CMD_CREATE  = 2'd1;
	localparam logic [1:0] CMD_RELEASE = 2'd2;

	localparam logic [31:0] FIRST_ID_RESET = 32'd1;
	localparam logic [31:0] LAZY_MAX = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [1:0]  command;
		logic [30:0] object_type;
		logic [63:0] address;
	} req_t;

	typedef struct packed {
		logic [63:0] handle_id;
		logic        minted;
		logic        lazy_miss;
		logic        table_full;
		logic [31:0] lazy_total;
	} res_t;

	typedef struct packed {
		logic [30:0] object_type;
		logic [63:0] address;
		logic [63:0] id;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE
	} state_t;

endpackage

[hw/rtl/handle_to_id_translation_table.sv]
// handle to id translation table: associative (type, address) to id map
//
// usage: present a request word with start high; it is taken when busy is low.
// busy stays high while the table is searched. configuration writes of the
// first id on the cfg channel are taken only while busy is low and load the id
// counter at once.
// a null address answers in the cycle after acceptance. any other request
// scans every entry of the table memory, one entry per cycle through its
// single read port, and then answers from a decide state; one request is
// in flight.
// the result word is shown for exactly one cycle with result_valid high and
// must be taken then; the receiver cannot stall.
// reset clears all entry valid bits (flip-flops), loads the id counter with 1
// and clears the lazy allocation count; no clearing pass is needed.
// a hit takes the matching entry; a new key takes the lowest free entry.
`timescale 1ns / 1ps
module handle_to_id_translation_table
	import htt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  req_t        request,
	output logic        result_valid,
	output res_t        result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);

	localparam logic [IDX_W:0] SCAN_END = (IDX_W + 1)'(TABLE_ENTRIES);

	state_t state_q, state_d;
	req_t req_q;
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [63:0] next_id_q;
	logic [31:0] lazy_q;
	logic [IDX_W:0] rd_idx_q;
	logic cmp_v_s1;
	logic [IDX_W-1:0] cmp_idx_s1;
	logic hit_q, free_q;
	logic [IDX_W-1:0] hit_idx_q, free_idx_q;
	logic [63:0] hit_id_q;
	logic rv_q;
	res_t res_q;

	logic ram_we;
	logic [IDX_W-1:0] ram_addr;
	entry_t ram_wdata, ram_rdata;
	logic key_match;

	htt_ram #(.WIDTH(ENT_W), .DEPTH(TABLE_ENTRIES)) u_ram (
		.clk(clk),
		.we(ram_we),
		.addr(ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	assign busy = (state_q != ST_IDLE);
	assign cfg_ready = !busy;
	assign result_valid = rv_q;
	assign result = res_q;

	assign key_match = valid_q[cmp_idx_s1] && (ram_rdata.object_type == req_q.object_type)
		&& (ram_rdata.address == req_q.address);

	// decide cycle writes the chosen slot when an id is minted
	logic use_slot, do_mint;
	logic [IDX_W-1:0] slot;
	always_comb begin
		slot = hit_q ? hit_idx_q : free_idx_q;
		use_slot = hit_q || free_q;
		do_mint = 1'b0;
		case (req_q.command)
			CMD_LOOKUP: do_mint = !hit_q && free_q;
			CMD_CREATE: do_mint = use_slot;
			default:    do_mint = 1'b0;
		endcase
	end

	always_comb begin
		ram_we = (state_q == ST_DECIDE) && do_mint;
		ram_addr = (state_q == ST_DECIDE) ? slot : rd_idx_q[IDX_W-1:0];
		ram_wdata.object_type = req_q.object_type;
		ram_wdata.address = req_q.address;
		ram_wdata.id = next_id_q;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start && request.address != 64'd0) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (rd_idx_q == SCAN_END) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			next_id_q <= {32'd0, FIRST_ID_RESET};
			lazy_q <= '0;
			rv_q <= 1'b0;
			cmp_v_s1 <= 1'b0;
			rd_idx_q <= '0;
			hit_q <= 1'b0;
			free_q <= 1'b0;
		end else begin
			rv_q <= (state_q == ST_DECIDE)
				|| (state_q == ST_IDLE && start && request.address == 64'd0);
			unique case (state_q)
				ST_IDLE: begin
					if (cfg_valid) begin
						next_id_q <= {32'd0, cfg_data};
					end
					if (start) begin
						rd_idx_q <= '0;
						cmp_v_s1 <= 1'b0;
						hit_q <= 1'b0;
						free_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					cmp_v_s1 <= (rd_idx_q != SCAN_END);
					if (rd_idx_q != SCAN_END) begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
					if (cmp_v_s1) begin
						if (key_match && !hit_q) begin
							hit_q <= 1'b1;
						end
						if (!valid_q[cmp_idx_s1] && !free_q) begin
							free_q <= 1'b1;
						end
					end
				end
				ST_DECIDE: begin
					if (do_mint) begin
						valid_q[slot] <= 1'b1;
						next_id_q <= next_id_q + 64'd1;
						if (req_q.command == CMD_LOOKUP && lazy_q != LAZY_MAX) begin
							lazy_q <= lazy_q + 32'd1;
						end
					end
					if (req_q.command == CMD_RELEASE && hit_q) begin
						valid_q[hit_idx_q] <= 1'b0;
					end
				end
				default: cmp_v_s1 <= 1'b0;
			endcase
		end
	end

	// result word of the decide cycle
	logic lazy_sat;
	res_t dec_res;
	assign lazy_sat = (lazy_q == LAZY_MAX);
	always_comb begin
		dec_res.handle_id = 64'd0;
		dec_res.minted = do_mint;
		dec_res.lazy_miss = 1'b0;
		dec_res.table_full = 1'b0;
		dec_res.lazy_total = lazy_q;
		case (req_q.command)
			CMD_LOOKUP: begin
				if (hit_q) begin
					dec_res.handle_id = hit_id_q;
				end else if (free_q) begin
					dec_res.handle_id = next_id_q;
					dec_res.lazy_miss = 1'b1;
					dec_res.lazy_total = lazy_sat ? lazy_q : lazy_q + 32'd1;
				end else begin
					dec_res.table_full = 1'b1;
				end
			end
			CMD_CREATE: begin
				if (use_slot) begin
					dec_res.handle_id = next_id_q;
				end else begin
					dec_res.table_full = 1'b1;
				end
			end
			default: dec_res.handle_id = 64'd0;
		endcase
	end

	// payload registers
	always_ff @(posedge clk) begin
		cmp_idx_s1 <= rd_idx_q[IDX_W-1:0];
		if (state_q == ST_IDLE && start) begin
			req_q <= request;
			res_q <= '{handle_id: 64'd0, minted: 1'b0, lazy_miss: 1'b0,
				table_full: 1'b0, lazy_total: lazy_q};
		end else if (state_q == ST_DECIDE) begin
			res_q <= dec_res;
		end
		if (state_q == ST_SCAN && cmp_v_s1) begin
			if (key_match && !hit_q) begin
				hit_idx_q <= cmp_idx_s1;
				hit_id_q <= ram_rdata.id;
			end
			if (!valid_q[cmp_idx_s1] && !free_q) begin
				free_idx_q <= cmp_idx_s1;
			end
		end
	end

`ifndef SYNTHESIS
	a_full_no_mint: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.table_full |-> !result.minted)
		else $error("table full result also minted");
	a_lazy_mints: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.lazy_miss |-> result.minted)
		else $error("lazy miss without minted id");
	a_cfg_load: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> next_id_q == {32'd0, $past(cfg_data)})
		else $error("id counter not loaded by config write");
	a_lazy_mono: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_DECIDE |=> lazy_q == $past(lazy_q))
		else $error("lazy count changed outside decide");
`endif

endmodule

[hw/rtl/htt_ram.sv]
// generic single port ram with registered read
`timescale 1ns / 1ps
module htt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

[sim/handle_to_id_translation_table_test.sv]
// self-checking testbench of the handle to id translation table
`timescale 1ns / 1ps
module handle_to_id_translation_table_test;
	import htt_pkg::*;

	localparam int LIMIT_CYCLES = 3000000;
	localparam logic [1:0] CMD_NOP = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	req_t request = '0;
	logic result_valid;
	res_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [31:0] cfg_data = '0;

	handle_to_id_translation_table dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .request(request),
		.result_valid(result_valid), .result(result), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// shadow of the table
	logic        tab_valid [TABLE_ENTRIES];
	logic [30:0] tab_type [TABLE_ENTRIES];
	logic [63:0] tab_addr [TABLE_ENTRIES];
	logic [63:0] tab_id [TABLE_ENTRIES];
	logic [63:0] id_counter;
	logic [31:0] lazy_count;

	req_t pending_words[$];
	res_t expected_words[$];
	logic [31:0] cfg_pending[$];
	int mismatches = 0;
	int cycles = 0;
	int gap = 0;
	bit calm = 1'b0;
	bit in_flight = 1'b0;

	function automatic int key_slot(logic [30:0] t, logic [63:0] a);
		for (int i = 0; i < TABLE_ENTRIES; i++)
			if (tab_valid[i] && tab_type[i] == t && tab_addr[i] == a) return i;
		return -1;
	endfunction

	function automatic int free_slot();
		for (int i = 0; i < TABLE_ENTRIES; i++)
			if (!tab_valid[i]) return i;
		return -1;
	endfunction

	function automatic res_t translate(req_t r);
		res_t o;
		int s;
		bit add;
		o = '0;
		if (r.address != 64'd0) begin
			s = key_slot(r.object_type, r.address);
			add = 1'b0;
			if (r.command == CMD_LOOKUP) begin
				if (s >= 0) o.handle_id = tab_id[s];
				else begin
					s = free_slot();
					if (s < 0) o.table_full = 1'b1;
					else begin
						add = 1'b1;
						o.lazy_miss = 1'b1;
						if (lazy_count != LAZY_MAX) lazy_count++;
					end
				end
			end else if (r.command == CMD_CREATE) begin
				if (s < 0) s = free_slot();
				if (s < 0) o.table_full = 1'b1;
				else add = 1'b1;
			end else if (r.command == CMD_RELEASE) begin
				if (s >= 0) tab_valid[s] = 1'b0;
			end
			if (add) begin
				o.handle_id = id_counter;
				o.minted = 1'b1;
				id_counter = id_counter + 64'd1;
				tab_valid[s] = 1'b1;
				tab_type[s] = r.object_type;
				tab_addr[s] = r.address;
				tab_id[s] = o.handle_id;
			end
		end
		o.lazy_total = lazy_count;
		return o;
	endfunction

	// driver: config words go first when idle, then request words
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				id_counter = {32'd0, cfg_data};
				void'(cfg_pending.pop_front());
				cfg_valid <= 1'b0;
			end else if (start && !busy) begin
				expected_words = {expected_words, translate(request)};
				void'(pending_words.pop_front());
				in_flight = 1'b1;
				start <= 1'b0;
			end else if (!start && !cfg_valid) begin
				if (gap > 0) gap--;
				else if (!calm && $urandom_range(0, 9) == 0) gap = $urandom_range(1, 8);
				else if (cfg_pending.size() > 0 && pending_words.size() == 0 &&
						expected_words.size() == 0 && !in_flight) begin
					cfg_data <= cfg_pending[0];
					cfg_valid <= 1'b1;
				end else if (pending_words.size() > 0 && cfg_pending.size() == 0) begin
					request <= pending_words[0];
					start <= 1'b1;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		cycles++;
		if (arst_n && result_valid) begin
			in_flight = 1'b0;
			if (expected_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result word %h", result);
			end else begin
				if (result !== expected_words[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %h actual %h", expected_words[0], result);
				end
				void'(expected_words.pop_front());
			end
		end
		if (cycles > LIMIT_CYCLES) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic req_t mk(logic [1:0] c, logic [30:0] t, logic [63:0] a);
		req_t r;
		r.command = c;
		r.object_type = t;
		r.address = a;
		return r;
	endfunction

	task automatic add_word(req_t r);
		pending_words = {pending_words, r};
	endtask

	task automatic drain();
		wait (pending_words.size() == 0 && expected_words.size() == 0 && !in_flight);
	endtask

	task automatic set_first(logic [31:0] v);
		drain();
		repeat (5) @(posedge clk);
		cfg_pending = {cfg_pending, v};
		wait (cfg_pending.size() == 0);
	endtask

	function automatic logic [63:0] rnd64();
		return {$urandom(), $urandom()};
	endfunction

	// random phase over a small key pool so hits, releases and refills happen
	task automatic random_items(int n, int pool);
		logic [1:0] c;
		logic [30:0] t;
		logic [63:0] a;
		for (int i = 0; i < n; i++) begin
			c = $urandom_range(0, 9) < 5 ? CMD_LOOKUP : 2'($urandom_range(0, 3));
			if ($urandom_range(0, 9) == 0) begin
				t = 31'($urandom());
				a = $urandom_range(0, 3) == 0 ? 64'd0 : rnd64();
			end else begin
				t = $urandom_range(0, 1) ? 31'h7FFF_FFFF : 31'($urandom_range(0, 2));
				a = 64'($urandom_range(1, pool))
					| ($urandom_range(0, 1) ? 64'hFFFF_0000_0000_0000 : 64'd0);
			end
			add_word(mk(c, t, a));
		end
	endtask

	initial begin
		for (int i = 0; i < TABLE_ENTRIES; i++) tab_valid[i] = 1'b0;
		id_counter = {32'd0, FIRST_ID_RESET};
		lazy_count = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		// directed: null address, each command, absent release, nop, extremes
		add_word(mk(CMD_LOOKUP, 31'h7FFF_FFFF, 64'd0));
		add_word(mk(CMD_CREATE, 31'd5, 64'd0));
		add_word(mk(CMD_RELEASE, 31'd5, 64'd9));
		add_word(mk(CMD_LOOKUP, 31'h7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF));
		add_word(mk(CMD_LOOKUP, 31'h7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF));
		add_word(mk(CMD_CREATE, 31'h7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF));
		add_word(mk(CMD_LOOKUP, 31'd0, 64'd1));
		add_word(mk(CMD_NOP, 31'd0, 64'd1));
		add_word(mk(CMD_RELEASE, 31'd0, 64'd1));
		add_word(mk(CMD_LOOKUP, 31'd0, 64'd1));
		add_word(mk(CMD_CREATE, 31'd3, 64'd77));
		drain();
		set_first(32'hFFFF_FFFF);
		add_word(mk(CMD_CREATE, 31'd1, 64'd2));
		add_word(mk(CMD_CREATE, 31'd1, 64'd3));
		add_word(mk(CMD_LOOKUP, 31'd1, 64'd2));
		set_first(32'd0);
		// fill the table then probe it full
		for (int i = 0; i < TABLE_ENTRIES + 2; i++)
			add_word(mk(CMD_LOOKUP, 31'd9, 64'h100 + 64'(i)));
		add_word(mk(CMD_CREATE, 31'd9, 64'h5000));
		add_word(mk(CMD_CREATE, 31'd9, 64'h100));
		// free a quarter so the random phase both fills and overflows
		for (int i = 0; i < TABLE_ENTRIES / 4; i++)
			add_word(mk(CMD_RELEASE, 31'd9, 64'h100 + 64'(i)));
		set_first($urandom());
		random_items(80, 12);
		set_first(32'd1);
		random_items(40, 40);
		drain();
		calm = 1'b1;
		random_items(40, 12);
		drain();
		repeat (300) @(posedge clk);
		if (mismatches == 0 && expected_words.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
